// ===== sv/dcrd_pkg.sv =====
// Shared types and constants of the daisy chain readout deframer.
`default_nettype none

package dcrd_pkg;

    // Field widths of one input word and one result word
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 9;
    localparam int VALUE_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DEVICE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUES_PER_DEV = 2'd3;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] sample_index;
        logic [VALUE_W-1:0] sample_value;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/dcrd_item_if.sv =====
// Input channel: command words and received bytes.
`default_nettype none

interface dcrd_item_if
    import dcrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/dcrd_result_if.sv =====
// Result channel: samples, done and frame error words.
`default_nettype none

interface dcrd_result_if
    import dcrd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] sample_index;
    logic [VALUE_W-1:0] sample_value;
    logic               last;

    modport source (output valid, output kind, output sample_index, output sample_value,
                    output last, input ready);
    modport sink   (input valid, input kind, input sample_index, input sample_value,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/daisy_chain_readout_deframer.sv =====
// Top level of the daisy chain readout deframer: parser, result register and skid stage.
//
//  channel   dir  handshake      payload
//  item      in   valid/ready    command[1:0], rx_byte[7:0]
//  result    out  valid/ready    kind[1:0], sample_index[8:0], sample_value[15:0], last
//  cfg       in   cfg_we         cfg_index[1:0], cfg_data[5:0]
//
// One word per clock while item.ready is high: the parser state advances in the cycle a
// word is accepted; any result is registered in the output register, or, while that one
// waits, in the skid stage, so item.ready stays high; it drops only when both are full.
// rst_n clears the parser to idle, empties both result stages and loads register defaults.
`default_nettype none

module daisy_chain_readout_deframer
    import dcrd_pkg::*;
#(
    parameter int MAX_DEVICES = 16,
    parameter int MAX_VALUES  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dcrd_item_if.sink                  item,
    dcrd_result_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Derived widths
    localparam int DEV_W   = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int VW      = $clog2(MAX_VALUES + 1);
    localparam int CMP_W   = (VW > CFG_DATA_W) ? VW : CFG_DATA_W;
    localparam int HDR_W   = (VW + 1 > BYTE_W) ? VW + 1 : BYTE_W;
    localparam int PROD_W  = DEV_W + VW + 1;
    localparam int WIDE_W  = (PROD_W > INDEX_W) ? PROD_W : INDEX_W;

    localparam logic [CMP_W-1:0] MAX_VALUES_C  = CMP_W'(MAX_VALUES);
    localparam logic [4:0]       MAX_DEVICES_C = 5'(MAX_DEVICES);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_HI,
        PH_LO,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    // Configuration registers
    logic [4:0] chain_length_reg;
    logic [3:0] first_device_reg;
    logic [4:0] device_count_reg;
    logic [5:0] values_per_dev_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic [DEV_W-1:0]  dev_cnt_reg, dev_cnt_next;
    logic [VW-1:0]     val_cnt_reg, val_cnt_next;
    logic [BYTE_W-1:0] high_byte_reg, high_byte_next;

    // Result register and skid stage
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    item_fire, out_fire;
    logic    res_valid;
    result_t res;

    // Effective limits
    logic [VW-1:0]     vpd_eff;
    logic [4:0]        len_eff;
    logic [HDR_W-1:0]  hdr_expect;
    logic              keep;
    logic [4:0]        dev_diff;
    logic [VW-1:0]     rev_pos;
    logic [VW-1:0]     pos_inc;
    logic [WIDE_W-1:0] index_wide;

    assign item_fire   = item.valid && item.ready;
    assign out_fire    = out_valid_reg && result.ready;
    assign item.ready  = !skid_valid_reg;

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.sample_index = out_reg.sample_index;
    assign result.sample_value = out_reg.sample_value;
    assign result.last         = out_reg.last;

    // Saturate register values and derive the expected header
    always_comb
    begin
        if (CMP_W'(values_per_dev_reg) > MAX_VALUES_C)
            vpd_eff = VW'(MAX_VALUES);
        else
            vpd_eff = VW'(values_per_dev_reg);
        len_eff    = (chain_length_reg > MAX_DEVICES_C) ? MAX_DEVICES_C : chain_length_reg;
        hdr_expect = HDR_W'({vpd_eff, 1'b0}) - HDR_W'(1);
    end

    // Sample position and window check
    always_comb
    begin
        keep = (6'(dev_cnt_reg) >= 6'(first_device_reg)) &&
               (6'(dev_cnt_reg) < 6'(first_device_reg) + 6'(device_count_reg));
        dev_diff = 5'(dev_cnt_reg) - 5'(first_device_reg);
        rev_pos  = (val_cnt_reg < vpd_eff) ? (vpd_eff - VW'(1) - val_cnt_reg) : '0;
        pos_inc  = val_cnt_reg + VW'(1);
        index_wide = WIDE_W'(dev_diff[DEV_W-1:0]) * WIDE_W'(vpd_eff) + WIDE_W'(rev_pos);
    end

    // Parser next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        dev_cnt_next   = dev_cnt_reg;
        val_cnt_next   = val_cnt_reg;
        high_byte_next = high_byte_reg;
        res_valid      = 1'b0;
        res.kind         = KIND_DONE;
        res.sample_index = '0;
        res.sample_value = '0;
        res.last         = 1'b1;

        if (item_fire)
        begin
            if (item.command == CMD_START)
            begin
                val_cnt_next   = '0;
                high_byte_next = '0;
                if (len_eff == 5'd0)
                begin
                    phase_next   = PH_IDLE;
                    dev_cnt_next = '0;
                    res_valid    = 1'b1;
                end
                else
                begin
                    dev_cnt_next = DEV_W'(len_eff - 5'd1);
                    phase_next   = PH_HEADER;
                end
            end
            else if (item.command == CMD_TIMEOUT && phase_reg != PH_IDLE)
            begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.kind   = KIND_ERROR;
            end
            else if (item.command == CMD_BYTE)
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_HEADER:
                    begin
                        if (vpd_eff == '0 || HDR_W'(item.rx_byte) != hdr_expect)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = KIND_ERROR;
                        end
                        else
                        begin
                            val_cnt_next = '0;
                            phase_next   = PH_HI;
                        end
                    end
                    PH_HI:
                    begin
                        high_byte_next = item.rx_byte;
                        phase_next     = PH_LO;
                    end
                    PH_LO:
                    begin
                        val_cnt_next = pos_inc;
                        phase_next   = (pos_inc >= vpd_eff) ? PH_CRC0 : PH_HI;
                        if (keep)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_SAMPLE;
                            res.sample_index = index_wide[INDEX_W-1:0];
                            res.sample_value = {high_byte_reg, item.rx_byte};
                            res.last         = 1'b0;
                        end
                    end
                    PH_CRC0:
                    begin
                        phase_next = PH_CRC1;
                    end
                    PH_CRC1:
                    begin
                        if (dev_cnt_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            dev_cnt_next = dev_cnt_reg - DEV_W'(1);
                            phase_next   = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg   <= 5'd1;
            first_device_reg   <= 4'd0;
            device_count_reg   <= 5'd16;
            values_per_dev_reg <= 6'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHAIN_LENGTH:   chain_length_reg   <= cfg_data[4:0];
                REG_FIRST_DEVICE:   first_device_reg   <= cfg_data[3:0];
                REG_DEVICE_COUNT:   device_count_reg   <= cfg_data[4:0];
                REG_VALUES_PER_DEV: values_per_dev_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            dev_cnt_reg   <= '0;
            val_cnt_reg   <= '0;
            high_byte_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dev_cnt_reg   <= dev_cnt_next;
            val_cnt_reg   <= val_cnt_next;
            high_byte_reg <= high_byte_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    // The skid stage only ever holds a word behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // A start on a non-empty chain always arms the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.command == CMD_START && len_eff != 5'd0) |=> phase_reg == PH_HEADER)
        else $error("start did not arm the header phase");

    // A done or frame error word leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> phase_reg == PH_IDLE)
        else $error("parser still active after closing word");

    // Nothing is produced from an idle parser except on a start
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && item.command != CMD_START) |-> !res_valid)
        else $error("result produced while idle");

endmodule

`default_nettype wire
